@@ design/jfc_pkg.sv @@
// ----------------------------------------------------------------------------
// jfc_pkg
// Types and constants shared by the feed-drive controller and hour meter.
// ----------------------------------------------------------------------------
package jfc_pkg;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_TICKS_PER_SECOND = 2'd0;
  localparam logic [1:0] REG_SAVE_INTERVAL    = 2'd1;
  localparam logic [1:0] REG_RAMP_STEP        = 2'd2;
  localparam logic [1:0] REG_SPEED_MAX        = 2'd3;

  // Register reset values.
  localparam logic [7:0] TICKS_PER_SECOND_RST = 8'd20;
  localparam logic [9:0] SAVE_INTERVAL_RST    = 10'd800;
  localparam logic [9:0] RAMP_STEP_RST        = 10'd80;
  localparam logic [9:0] SPEED_MAX_RST        = 10'd800;

  // Status codes.
  localparam logic [3:0] ST_STOP          = 4'd0;
  localparam logic [3:0] ST_FWD           = 4'd1;
  localparam logic [3:0] ST_FWD_FAST      = 4'd2;
  localparam logic [3:0] ST_FWD_LIMIT     = 4'd3;
  localparam logic [3:0] ST_REW           = 4'd4;
  localparam logic [3:0] ST_REW_FAST      = 4'd5;
  localparam logic [3:0] ST_REW_LIMIT     = 4'd6;
  localparam logic [3:0] ST_FEED_FAULT    = 4'd7;
  localparam logic [3:0] ST_SPINDLE_FAULT = 4'd8;
  localparam logic [3:0] ST_WAITING       = 4'd9;
  localparam logic [3:0] ST_TICK          = 4'd10;

  // Item kinds.
  localparam logic MODE_TICK    = 1'b0;
  localparam logic MODE_CONTROL = 1'b1;

  localparam logic [5:0] SIXTY = 6'd60;

  // Maintenance windows: these hours to MAINT_SPAN later, minute 0 (0-1 at H0).
  localparam logic [15:0] MAINT_H0 = 16'd500;
  localparam logic [15:0] MAINT_H1 = 16'd1000;
  localparam logic [15:0] MAINT_H2 = 16'd1500;
  localparam logic [15:0] MAINT_H3 = 16'd2000;
  localparam logic [15:0] MAINT_H4 = 16'd2500;
  localparam logic [15:0] MAINT_SPAN = 16'd2;

  typedef struct packed {
    logic       mode;
    logic       fwd_switch;
    logic       rew_switch;
    logic       fwd_fast_switch;
    logic       rew_fast_switch;
    logic       fwd_limit;
    logic       rew_limit;
    logic       feed_fault;
    logic       spindle_fault;
    logic [9:0] feed_pot;
  } item_t;

  typedef struct packed {
    logic signed [10:0] speed_command;
    logic               command_valid;
    logic [3:0]         drive_status;
    logic               buzzer;
    logic               maintenance_due;
    logic               save_request;
    logic [15:0]        saved_hours;
    logic [5:0]         saved_minutes;
  } result_t;

  typedef struct packed {
    logic        armed;
    logic        buzz;
    logic [9:0]  speed_level;
    logic [9:0]  save_counter;
    logic [7:0]  tick_counter;
    logic [5:0]  seconds_count;
    logic [5:0]  minutes_count;
    logic [15:0] hours_count;
  } state_t;

  typedef struct packed {
    logic [7:0] ticks_per_second;
    logic [9:0] save_interval;
    logic [9:0] ramp_step;
    logic [9:0] speed_max;
  } cfg_t;

endpackage

@@ design/jfc_core.sv @@
// ----------------------------------------------------------------------------
// jfc_core
// Next-state and result logic for one item: hour meter on ticks, drive
// command, status and warnings on control passes.
// ----------------------------------------------------------------------------
module jfc_core (
  input  jfc_pkg::item_t   item,
  input  jfc_pkg::state_t  state,
  input  jfc_pkg::cfg_t    cfg,
  output jfc_pkg::state_t  state_next,
  output jfc_pkg::result_t result
);

  logic maint;

  always_comb begin
    logic [15:0] h;
    h = state.hours_count;
    maint = 1'b0;
    if (h >= jfc_pkg::MAINT_H0 && h <= jfc_pkg::MAINT_H0 + jfc_pkg::MAINT_SPAN
        && state.minutes_count <= 6'd1) begin
      maint = 1'b1;
    end else if (state.minutes_count == 6'd0) begin
      maint = (h >= jfc_pkg::MAINT_H1 && h <= jfc_pkg::MAINT_H1 + jfc_pkg::MAINT_SPAN) ||
              (h >= jfc_pkg::MAINT_H2 && h <= jfc_pkg::MAINT_H2 + jfc_pkg::MAINT_SPAN) ||
              (h >= jfc_pkg::MAINT_H3 && h <= jfc_pkg::MAINT_H3 + jfc_pkg::MAINT_SPAN) ||
              (h >= jfc_pkg::MAINT_H4 && h <= jfc_pkg::MAINT_H4 + jfc_pkg::MAINT_SPAN);
    end
  end

  always_comb begin
    logic [9:0]  sc;
    logic [7:0]  tc;
    logic [5:0]  sec;
    logic [5:0]  mins;
    logic [10:0] ramp_sum;
    logic [9:0]  ramped;
    logic        ramp_ok;
    logic        flhit;
    logic        rlhit;
    logic        neg;
    logic [9:0]  mag;
    logic [9:0]  lvl;

    state_next = state;
    result     = '0;
    neg        = 1'b0;
    mag        = '0;
    sc         = state.save_counter + 10'd1;
    tc         = state.tick_counter + 8'd1;
    sec        = state.seconds_count + 6'd1;
    mins       = state.minutes_count + 6'd1;
    flhit      = item.fwd_limit && (item.fwd_switch || item.fwd_fast_switch);
    rlhit      = item.rew_limit && (item.rew_switch || item.rew_fast_switch);
    // Ramping only runs with a fast switch on, so it always starts from the
    // stored level.
    ramp_ok    = state.speed_level < cfg.speed_max;
    ramp_sum   = {1'b0, state.speed_level} + {1'b0, cfg.ramp_step};
    ramped     = (ramp_sum > {1'b0, cfg.speed_max}) ? cfg.speed_max : ramp_sum[9:0];
    lvl        = (!item.fwd_fast_switch && !item.rew_fast_switch) ?
                 {1'b0, item.feed_pot[9:1]} : state.speed_level;

    if (item.mode == jfc_pkg::MODE_TICK) begin
      result.drive_status = jfc_pkg::ST_TICK;
      // A zero interval compares as always reached, like an interval of one.
      if (sc >= cfg.save_interval) begin
        state_next.save_counter = '0;
        result.save_request     = 1'b1;
        result.saved_hours      = state.hours_count;
        result.saved_minutes    = state.minutes_count;
      end else begin
        state_next.save_counter = sc;
      end
      if (tc >= cfg.ticks_per_second) begin
        state_next.tick_counter = '0;
        if (sec >= jfc_pkg::SIXTY) begin
          state_next.seconds_count = '0;
          if (mins >= jfc_pkg::SIXTY) begin
            state_next.minutes_count = '0;
            state_next.hours_count   = state.hours_count + 16'd1;
          end else begin
            state_next.minutes_count = mins;
          end
        end else begin
          state_next.seconds_count = sec;
        end
      end else begin
        state_next.tick_counter = tc;
      end
    end else if (!state.armed && (item.fwd_switch || item.rew_switch ||
                                  item.fwd_fast_switch || item.rew_fast_switch)) begin
      result.drive_status = jfc_pkg::ST_WAITING;
    end else begin
      state_next.armed     = 1'b1;
      result.command_valid = 1'b1;
      if (item.feed_fault || item.spindle_fault) begin
        result.drive_status = item.feed_fault ? jfc_pkg::ST_FEED_FAULT :
                                                jfc_pkg::ST_SPINDLE_FAULT;
        state_next.buzz     = 1'b1;
      end else begin
        result.maintenance_due = maint;
        state_next.speed_level = lvl;
        state_next.buzz        = flhit || rlhit;
        if (flhit) begin
          result.drive_status = jfc_pkg::ST_FWD_LIMIT;
        end else if (item.fwd_fast_switch && (item.fwd_switch || !item.rew_switch)) begin
          result.drive_status = jfc_pkg::ST_FWD_FAST;
          result.command_valid = ramp_ok;
          if (ramp_ok) begin
            state_next.speed_level = ramped;
            mag = ramped;
          end
        end else if (item.fwd_switch) begin
          result.drive_status = jfc_pkg::ST_FWD;
          mag = lvl;
        end else if (rlhit) begin
          result.drive_status = jfc_pkg::ST_REW_LIMIT;
        end else if (item.rew_fast_switch && (item.rew_switch || !item.fwd_switch)) begin
          result.drive_status = jfc_pkg::ST_REW_FAST;
          result.command_valid = ramp_ok;
          if (ramp_ok) begin
            state_next.speed_level = ramped;
            mag = ramped;
            neg = 1'b1;
          end
        end else if (item.rew_switch) begin
          result.drive_status = jfc_pkg::ST_REW;
          mag = lvl;
          neg = 1'b1;
        end else begin
          result.drive_status = jfc_pkg::ST_STOP;
        end
      end
    end

    result.speed_command = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    result.buzzer        = state_next.buzz;
  end

endmodule

@@ design/jog_feed_controller_hour_meter.sv @@
// An accepted item is held in the input register until its result is loaded.
// Throughput: one item per cycle; the input register and the result register
// both advance whenever the result register is empty or being taken.
// Reset (synchronous, active high) disarms the drive, clears all counters,
// the speed level and the buzzer, and loads the register defaults.
// ----------------------------------------------------------------------------
// jog_feed_controller_hour_meter
// Feed-drive controller with run-hour meter, one input and one result
// register around the per-item logic.
// ----------------------------------------------------------------------------
module jog_feed_controller_hour_meter (
  input  logic               clk,
  input  logic               rst,
  // Input item channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               mode,
  input  logic               fwd_switch,
  input  logic               rew_switch,
  input  logic               fwd_fast_switch,
  input  logic               rew_fast_switch,
  input  logic               fwd_limit,
  input  logic               rew_limit,
  input  logic               feed_fault,
  input  logic               spindle_fault,
  input  logic [9:0]         feed_pot,
  // Result channel.
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [10:0] speed_command,
  output logic               command_valid,
  output logic [3:0]         drive_status,
  output logic               buzzer,
  output logic               maintenance_due,
  output logic               save_request,
  output logic [15:0]        saved_hours,
  output logic [5:0]         saved_minutes,
  // Configuration write channel.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [9:0]         cfg_data
);

  jfc_pkg::item_t   item;
  logic             item_valid;
  jfc_pkg::state_t  state;
  jfc_pkg::state_t  state_next;
  jfc_pkg::cfg_t    cfg;
  jfc_pkg::result_t result_next;
  jfc_pkg::result_t result;

  logic out_load;
  logic advance;

  assign out_load  = !out_valid || !out_stall;
  assign advance   = item_valid && out_load;
  assign in_stall  = item_valid && !out_load;
  assign cfg_ready = 1'b1;

  jfc_core u_core (
    .item       (item),
    .state      (state),
    .cfg        (cfg),
    .state_next (state_next),
    .result     (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.mode            <= mode;
      item.fwd_switch      <= fwd_switch;
      item.rew_switch      <= rew_switch;
      item.fwd_fast_switch <= fwd_fast_switch;
      item.rew_fast_switch <= rew_fast_switch;
      item.fwd_limit       <= fwd_limit;
      item.rew_limit       <= rew_limit;
      item.feed_fault      <= feed_fault;
      item.spindle_fault   <= spindle_fault;
      item.feed_pot        <= feed_pot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ticks_per_second <= jfc_pkg::TICKS_PER_SECOND_RST;
      cfg.save_interval    <= jfc_pkg::SAVE_INTERVAL_RST;
      cfg.ramp_step        <= jfc_pkg::RAMP_STEP_RST;
      cfg.speed_max        <= jfc_pkg::SPEED_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        jfc_pkg::REG_TICKS_PER_SECOND: cfg.ticks_per_second <= cfg_data[7:0];
        jfc_pkg::REG_SAVE_INTERVAL:    cfg.save_interval    <= cfg_data;
        jfc_pkg::REG_RAMP_STEP:        cfg.ramp_step        <= cfg_data;
        jfc_pkg::REG_SPEED_MAX:        cfg.speed_max        <= cfg_data;
        default: ;
      endcase
    end
  end

  assign speed_command   = result.speed_command;
  assign command_valid   = result.command_valid;
  assign drive_status    = result.drive_status;
  assign buzzer          = result.buzzer;
  assign maintenance_due = result.maintenance_due;
  assign save_request    = result.save_request;
  assign saved_hours     = result.saved_hours;
  assign saved_minutes   = result.saved_minutes;

endmodule
